@@ design/quintic_waypoint_trajectory_generator_core_assert.svh @@
// assertion macros used by the checker file
`ifndef QUINTIC_WAYPOINT_TRAJECTORY_GENERATOR_CORE_ASSERT_SVH
`define QUINTIC_WAYPOINT_TRAJECTORY_GENERATOR_CORE_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define QWTG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define QWTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/qwtg_pkg.sv @@
// ----------------------------------------------------------------------------
// qwtg_pkg
// shared constants, status codes and types of the quintic waypoint player
// ----------------------------------------------------------------------------
package qwtg_pkg;

    localparam int JOINTS  = 7;
    localparam int QDEPTH  = 128;
    localparam int QA_W    = $clog2(QDEPTH);
    localparam int CNT_W   = $clog2(QDEPTH + 1);
    localparam int TIME_W  = 48;
    localparam int FRAC    = 30;
    localparam int SM_W    = FRAC + 1;
    localparam int POS_W   = 32;
    localparam int DELTA_W = POS_W + 1;
    localparam int DUR_W   = 26;
    localparam int PER_W   = 16;
    localparam int STAT_W  = 3;
    localparam int DCNT_W  = $clog2(FRAC + 1);
    localparam int IN_W    = ((PER_W + JOINTS * POS_W + DUR_W + 7) / 8) * 8;
    localparam int OUT_W   = ((JOINTS * POS_W + 7) / 8) * 8;
    localparam int ROW_W   = DUR_W + JOINTS * POS_W;

    // polynomial coefficients of 10s^3 - 15s^4 + 6s^5
    localparam int C_CUBE  = 10;
    localparam int C_QUART = 15;
    localparam int C_QUINT = 6;

    localparam logic [STAT_W-1:0] ST_PASS   = 3'd0;
    localparam logic [STAT_W-1:0] ST_HOLD   = 3'd1;
    localparam logic [STAT_W-1:0] ST_START  = 3'd2;
    localparam logic [STAT_W-1:0] ST_INTERP = 3'd3;
    localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd4;
    localparam logic [STAT_W-1:0] ST_DROP   = 3'd5;

    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic signed [DELTA_W-1:0] t_delta;

    typedef struct packed {
        logic [DUR_W-1:0]         dur;
        logic [JOINTS*POS_W-1:0]  tgt;
    } t_row;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

@@ design/qwtg_phase_div.sv @@
// ----------------------------------------------------------------------------
// qwtg_phase_div
// restoring divider, one quotient bit per cycle, q0.30 phase num/den
// ----------------------------------------------------------------------------
module qwtg_phase_div
    import qwtg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_num,
    input  logic [TIME_W-1:0] i_den,
    output t_unit_stat        o_stat,
    output logic [FRAC-1:0]   o_quot
);

    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_den;
    logic [FRAC-1:0]   r_quot;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [TIME_W:0]   w_two;
    logic              w_ge;

    assign w_two = {r_rem, 1'b0};
    assign w_ge  = w_two >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // remainder stays below den, so it fits back in TIME_W bits
                r_rem  <= w_ge ? TIME_W'(w_two - {1'b0, r_den}) : w_two[TIME_W-1:0];
                r_quot <= {r_quot[FRAC-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(FRAC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

@@ design/qwtg_smooth.sv @@
// ----------------------------------------------------------------------------
// qwtg_smooth
// three-stage minimum-jerk shaping 10s^3 - 15s^4 + 6s^5, clamped to 1.0
// ----------------------------------------------------------------------------
module qwtg_smooth
    import qwtg_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [FRAC-1:0] i_s,
    output t_unit_stat      o_stat,
    output logic [SM_W-1:0] o_sm
);

    localparam logic [FRAC+4:0] ONE_X10 = (FRAC + 5)'(C_CUBE) << FRAC;

    logic [2:0]         r_vld;
    logic [FRAC-1:0]    r_s1;
    logic [FRAC-1:0]    r_s2;
    logic [FRAC-1:0]    r_s3;
    logic [FRAC+3:0]    r_inner;
    logic [SM_W-1:0]    r_sm;
    logic [2*FRAC-1:0]  w_sq;
    logic [2*FRAC-1:0]  w_cu;
    logic [FRAC+4:0]    w_inner;
    logic [3*FRAC+3:0]  w_fin;

    assign w_sq    = {{FRAC{1'b0}}, i_s} * {{FRAC{1'b0}}, i_s};
    assign w_cu    = {{FRAC{1'b0}}, r_s2} * {{FRAC{1'b0}}, r_s1};
    // 10 + 6s^2 - 15s stays positive over the whole phase range
    assign w_inner = ONE_X10 + {5'd0, r_s2} * (FRAC + 5)'(C_QUINT)
                   - {5'd0, r_s1} * (FRAC + 5)'(C_QUART);
    assign w_fin   = {{(FRAC + 4){1'b0}}, r_s3} * {{FRAC{1'b0}}, r_inner};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1    <= i_s;
        r_s2    <= w_sq[2*FRAC-1:FRAC];
        r_s3    <= w_cu[2*FRAC-1:FRAC];
        r_inner <= w_inner[FRAC+3:0];
        if (w_fin[3*FRAC+3:FRAC] > (2*FRAC + 4)'(1) << FRAC) begin
            r_sm <= SM_W'(1) << FRAC;
        end else begin
            r_sm <= w_fin[FRAC+SM_W-1:FRAC];
        end
    end

    assign o_stat.busy = |r_vld[1:0];
    assign o_stat.done = r_vld[2];
    assign o_sm        = r_sm;

endmodule

@@ design/qwtg_lane.sv @@
// ----------------------------------------------------------------------------
// qwtg_lane
// one joint: start + round(delta * smooth), product and sum each registered
// ----------------------------------------------------------------------------
module qwtg_lane
    import qwtg_pkg::*;
(
    input  logic            i_clk,
    input  t_delta          i_delta,
    input  t_pos            i_base,
    input  logic [SM_W-1:0] i_sm,
    output t_pos            o_pos
);

    localparam int PROD_W = DELTA_W + SM_W + 1;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_off;
    t_pos                     r_pos;

    assign w_prod = i_delta * $signed({1'b0, i_sm});
    // arithmetic shift gives round half up for both signs
    assign w_off  = r_prod >>> FRAC;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod + (PROD_W'(1) <<< (FRAC - 1));
        r_pos  <= i_base + t_pos'(w_off[POS_W-1:0]);
    end

    assign o_pos = r_pos;

endmodule

@@ design/quintic_waypoint_trajectory_generator_core.sv @@
// ----------------------------------------------------------------------------
// quintic_waypoint_trajectory_generator_core
// seven-joint waypoint player with fifo and quintic minimum-jerk interpolation
// ----------------------------------------------------------------------------
// sequence: waypoint, passthrough, hold and segment start items go from acceptance
//   through the evaluate and finish states to the output register; interpolating
//   ticks also pass compare, the phase divider, shaping and the lane pipeline;
//   a phase past the span skips divide and shaping
// throughput: one item at a time, next item taken once the result is queued
// reset: synchronous active low; clears time, segment, queue and plan state,
//   the waypoint ring memory is not cleared (only filled entries are read)
module quintic_waypoint_trajectory_generator_core
    import qwtg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // period_us[15:0], joint_0..joint_6 [239:16], duration_us[265:240], zero pad
    input  logic [IN_W-1:0]   s_axis_tdata,
    // func
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // pos_0..pos_6, 32 bits each from the lowest bit up
    output logic [OUT_W-1:0]  m_axis_tdata,
    // status
    output logic [STAT_W-1:0] m_axis_tuser
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SMTH = 3'd4;
    localparam logic [2:0] S_LANE = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic [SM_W-1:0] SM_ONE = SM_W'(1) << FRAC;

    logic [2:0]         r_state;

    // time and segment state
    logic [TIME_W-1:0]  r_elapsed;
    logic [TIME_W-1:0]  r_seg_start;
    logic [TIME_W-1:0]  r_seg_goal;
    t_pos               r_start_pos [JOINTS];
    t_delta             r_delta     [JOINTS];
    logic [QA_W-1:0]    r_head;
    logic [CNT_W-1:0]   r_count;
    logic               r_plan;

    // captured transaction
    logic               r_func;
    logic [TIME_W-1:0]  r_t;
    t_pos               r_q [JOINTS];
    logic [DUR_W-1:0]   r_dur;

    // waypoint ring, one row per waypoint, read port always at the head
    t_row               r_mem [QDEPTH];
    t_row               r_rd;
    logic               w_wr_en;
    logic [QA_W-1:0]    w_wr_addr;
    t_row               w_wr_row;
    logic [QA_W:0]      w_slot_sum;

    // phase and shaping
    logic [TIME_W-1:0]  r_num;
    logic [TIME_W-1:0]  r_den;
    logic [SM_W-1:0]    r_sm;
    logic [1:0]         r_lcnt;
    t_unit_stat         w_div_stat;
    t_unit_stat         w_sm_stat;
    logic [FRAC-1:0]    w_quot;
    logic [SM_W-1:0]    w_sm;
    logic               w_div_start;
    logic               w_sm_start;
    t_pos               w_lane_pos [JOINTS];

    // merged result and output register
    t_pos               r_res [JOINTS];
    logic [STAT_W-1:0]  r_res_stat;
    logic               r_out_valid;
    t_pos               r_out_pos [JOINTS];
    logic [STAT_W-1:0]  r_out_stat;

    logic               w_in_acc;
    logic               w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // ring slot for a push: (head + count) wrapped once
    assign w_slot_sum = {1'b0, r_head} + (QA_W + 1)'(r_count);
    always_comb begin
        if (w_slot_sum >= (QA_W + 1)'(QDEPTH)) begin
            w_wr_addr = QA_W'(w_slot_sum - (QA_W + 1)'(QDEPTH));
        end else begin
            w_wr_addr = w_slot_sum[QA_W-1:0];
        end
        w_wr_row.dur = r_dur;
        for (int j = 0; j < JOINTS; j++) begin
            w_wr_row.tgt[j*POS_W +: POS_W] = r_q[j];
        end
    end
    assign w_wr_en = (r_state == S_EVAL) && r_func && (r_count < CNT_W'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_row;
        end
        r_rd <= r_mem[r_head];
    end

    // shared phase divider and shaping unit
    assign w_div_start = (r_state == S_CMP) && (r_num < r_den);
    assign w_sm_start  = (r_state == S_DIV) && w_div_stat.done;

    qwtg_phase_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    qwtg_smooth u_smooth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sm_start),
        .i_s     (w_quot),
        .o_stat  (w_sm_stat),
        .o_sm    (w_sm)
    );

    // one lane per joint
    for (genvar g = 0; g < JOINTS; g++) begin : g_lane
        qwtg_lane u_lane (
            .i_clk   (i_clk),
            .i_delta (r_delta[g]),
            .i_base  (r_start_pos[g]),
            .i_sm    (r_sm),
            .o_pos   (w_lane_pos[g])
        );
    end

    // sequencer and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_seg_start <= '0;
            r_seg_goal  <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_plan      <= 1'b0;
            r_out_valid <= 1'b0;
            r_lcnt      <= '0;
            for (int j = 0; j < JOINTS; j++) begin
                r_start_pos[j] <= '0;
                r_delta[j]     <= '0;
            end
        end else begin
            // output register loads in the finish state, empties when taken
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_func <= s_axis_tuser;
                        r_t    <= r_elapsed + TIME_W'(s_axis_tdata[PER_W-1:0]);
                        r_dur  <= s_axis_tdata[PER_W+JOINTS*POS_W +: DUR_W];
                        for (int j = 0; j < JOINTS; j++) begin
                            r_q[j] <= s_axis_tdata[PER_W+j*POS_W +: POS_W];
                        end
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_FIN;
                    if (r_func) begin
                        // waypoint: push or drop, positions read as zero
                        for (int j = 0; j < JOINTS; j++) begin
                            r_res[j] <= '0;
                        end
                        if (r_count < CNT_W'(QDEPTH)) begin
                            r_count    <= r_count + 1'b1;
                            r_plan     <= 1'b1;
                            r_res_stat <= ST_ACCEPT;
                        end else begin
                            r_res_stat <= ST_DROP;
                        end
                    end else begin
                        r_elapsed <= r_t;
                        for (int j = 0; j < JOINTS; j++) begin
                            r_res[j] <= r_q[j];
                        end
                        if (!r_plan) begin
                            r_res_stat <= ST_PASS;
                        end else if (r_t == r_seg_start) begin
                            // zero-length tick: re-latch start, keep the target
                            for (int j = 0; j < JOINTS; j++) begin
                                r_start_pos[j] <= r_q[j];
                                r_delta[j]     <= t_delta'(
                                    (DELTA_W + 1)'(r_start_pos[j]) + (DELTA_W + 1)'(r_delta[j])
                                    - (DELTA_W + 1)'(r_q[j]));
                            end
                            r_res_stat <= ST_START;
                        end else if (r_t >= r_seg_goal) begin
                            if (r_count == '0) begin
                                r_res_stat <= ST_HOLD;
                            end else begin
                                // pop the head waypoint and open a segment
                                r_seg_start <= r_t;
                                r_seg_goal  <= r_t + TIME_W'(r_rd.dur);
                                for (int j = 0; j < JOINTS; j++) begin
                                    r_start_pos[j] <= r_q[j];
                                    r_delta[j]     <= DELTA_W'(
                                        t_pos'(r_rd.tgt[j*POS_W +: POS_W]))
                                        - DELTA_W'(r_q[j]);
                                end
                                r_head     <= (r_head == QA_W'(QDEPTH - 1)) ? '0
                                                                           : r_head + 1'b1;
                                r_count    <= r_count - 1'b1;
                                r_res_stat <= ST_START;
                            end
                        end else begin
                            r_num   <= r_t - r_seg_start;
                            r_den   <= r_seg_goal - r_seg_start;
                            r_state <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    // phase past the span only happens after a time wrap
                    if (r_num >= r_den) begin
                        r_sm    <= SM_ONE;
                        r_lcnt  <= '0;
                        r_state <= S_LANE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= S_SMTH;
                    end
                end
                S_SMTH: begin
                    if (w_sm_stat.done) begin
                        r_sm    <= w_sm;
                        r_lcnt  <= '0;
                        r_state <= S_LANE;
                    end
                end
                S_LANE: begin
                    r_lcnt <= r_lcnt + 1'b1;
                    if (r_lcnt == 2'd2) begin
                        for (int j = 0; j < JOINTS; j++) begin
                            r_res[j] <= w_lane_pos[j];
                        end
                        r_res_stat <= ST_INTERP;
                        r_state    <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        for (int j = 0; j < JOINTS; j++) begin
                            r_out_pos[j] <= r_res[j];
                        end
                        r_out_stat  <= r_res_stat;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output transaction
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_stat;
    always_comb begin
        m_axis_tdata = '0;
        for (int j = 0; j < JOINTS; j++) begin
            m_axis_tdata[j*POS_W +: POS_W] = r_out_pos[j];
        end
    end

endmodule

@@ design/qwtg_checker.sv @@
// ----------------------------------------------------------------------------
// qwtg_checker
// port-level checks of the waypoint player, bound to the top level
// ----------------------------------------------------------------------------
`include "quintic_waypoint_trajectory_generator_core_assert.svh"

module qwtg_checker
    import qwtg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic [STAT_W-1:0] m_axis_tuser
);

    `QWTG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    `QWTG_ASSERT_SAME(a_stat_range, m_axis_tvalid, m_axis_tuser <= ST_DROP, "status code out of range")
    `QWTG_ASSERT_SAME(a_wp_zero, m_axis_tvalid && (m_axis_tuser == ST_ACCEPT || m_axis_tuser == ST_DROP), m_axis_tdata == '0, "waypoint result carries positions")
    `QWTG_ASSERT_NEXT(a_busy_after_acc, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

endmodule

bind quintic_waypoint_trajectory_generator_core qwtg_checker u_qwtg_checker (.*);
